// File: rtl/core/fdc_pkg.sv
// shared types and constants for the frame descramble and check unit
package fdc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam logic [WORD_W-1:0] LEN_BIAS = 16'd6;

    typedef enum logic [2:0] {
        PH_LEN_LO  = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_ID_LO   = 3'd2,
        PH_ID_HI   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TRL_LO  = 3'd5,
        PH_TRL_HI  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_status;
        logic [WORD_W-1:0] msg_id;
        logic [WORD_W-1:0] frame_len;
        logic              check_ok;
        logic              last;
    } result_t;

endpackage

// File: rtl/core/fdc_deframe.sv
// header parse, payload descramble and trailer check for one byte per cycle while step is high
module fdc_deframe
    import fdc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [BYTE_W-1:0]   data,
    output logic                res_valid,
    output result_t             res
);

    phase_t             phase_reg, phase_next;
    logic [WORD_W-1:0]  len_reg, len_next;
    logic [WORD_W-1:0]  id_reg, id_next;
    logic [WORD_W-1:0]  left_reg, left_next;
    logic               key_sel_reg, key_sel_next;
    logic [BYTE_W-1:0]  trl_lo_reg, trl_lo_next;
    logic [WORD_W-1:0]  flen;
    logic [BYTE_W-1:0]  key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEN_LO;
            len_reg     <= '0;
            id_reg      <= '0;
            left_reg    <= '0;
            key_sel_reg <= 1'b0;
            trl_lo_reg  <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            id_reg      <= id_next;
            left_reg    <= left_next;
            key_sel_reg <= key_sel_next;
            trl_lo_reg  <= trl_lo_next;
        end
    end

    assign flen = len_reg + LEN_BIAS;
    assign key  = key_sel_reg ? id_reg[BYTE_W-1:0] : len_reg[BYTE_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        left_next    = left_reg;
        key_sel_next = key_sel_reg;
        trl_lo_next  = trl_lo_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.msg_id   = id_reg;
        res.frame_len = flen;
        unique case (phase_reg)
            PH_LEN_HI: begin
                len_next   = {data, len_reg[BYTE_W-1:0]};
                phase_next = PH_ID_LO;
            end
            PH_ID_LO: begin
                id_next    = {{(WORD_W-BYTE_W){1'b0}}, data};
                phase_next = PH_ID_HI;
            end
            PH_ID_HI: begin
                id_next      = {data, id_reg[BYTE_W-1:0]};
                left_next    = len_reg;
                key_sel_next = 1'b0;
                phase_next   = (len_reg != '0) ? PH_PAYLOAD : PH_TRL_LO;
            end
            PH_PAYLOAD: begin
                key_sel_next = ~key_sel_reg;
                left_next    = left_reg - 1'b1;
                if (left_reg == {{(WORD_W-1){1'b0}}, 1'b1}) begin
                    phase_next = PH_TRL_LO;
                end
                res_valid    = 1'b1;
                res.out_byte = data ^ key;
            end
            PH_TRL_LO: begin
                trl_lo_next = data;
                phase_next  = PH_TRL_HI;
            end
            PH_TRL_HI: begin
                phase_next    = PH_LEN_LO;
                res_valid     = 1'b1;
                res.is_status = 1'b1;
                res.check_ok  = ({data, trl_lo_reg} == flen);
                res.last      = 1'b1;
            end
            default: begin
                // first header byte, also the unused phase code
                len_next   = {{(WORD_W-BYTE_W){1'b0}}, data};
                phase_next = PH_LEN_HI;
            end
        endcase
    end

endmodule

// File: rtl/core/frame_descramble_check_unit.sv
// top level: input register, deframer and result register
// Takes one stream byte per cycle and gives at most one result per byte. The
// result is offered on the m_ side after the byte is taken: the byte is held
// in an input register, runs through the deframer logic, and the result lands
// in an output register when the held byte advances. Payload bytes come out
// descrambled as they arrive; the trailer's high byte yields one status result
// with last set and check_ok telling whether the trailer word matched payload
// length plus 6. Header bytes and the trailer's low byte give no result. Full
// rate holds as long as m_ready stays high; s_ready follows m_ready
// combinationally through the two stages.
module frame_descramble_check_unit
    import fdc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_in_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_out_byte,
    output logic                m_is_status,
    output logic [WORD_W-1:0]   m_msg_id,
    output logic [WORD_W-1:0]   m_frame_len,
    output logic                m_check_ok,
    output logic                m_last
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_vld_reg;
    result_t           out_reg;
    logic              advance;
    logic              res_valid;
    result_t           res;

    // held byte moves on when the result register is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    fdc_deframe u_deframe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data      (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= res_valid;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_out_byte  = out_reg.out_byte;
    assign m_is_status = out_reg.is_status;
    assign m_msg_id    = out_reg.msg_id;
    assign m_frame_len = out_reg.frame_len;
    assign m_check_ok  = out_reg.check_ok;
    assign m_last      = out_reg.last;

    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> m_last && (m_out_byte == '0))
        else $error("status beat malformed");

    a_payload_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_status |-> !m_last && !m_check_ok)
        else $error("payload beat carries status flags");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |-> !s_ready)
        else $error("input taken while both stages are stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(out_reg))
        else $error("result beat changed while stalled");

endmodule

// File: tb/tb_top.sv
// testbench for the frame descramble and check unit: directed frames, then random frames mixed with broken ones
`timescale 1ns / 1ps

module tb_top;
    import fdc_pkg::*;

    localparam int unsigned RAND_BEATS     = 1550;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 200;

    typedef struct {
        logic [BYTE_W-1:0] din;
        bit                typed;
        result_t           want;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_in_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_is_status;
    logic [WORD_W-1:0] m_msg_id;
    logic [WORD_W-1:0] m_frame_len;
    logic              m_check_ok;
    logic              m_last;

    // predictor state
    phase_t            cur_phase = PH_LEN_LO;
    logic [WORD_W-1:0] hdr_len = '0;
    logic [WORD_W-1:0] hdr_id = '0;
    logic [WORD_W-1:0] remain = '0;
    bit                use_id_key = 1'b0;
    logic [BYTE_W-1:0] trl_lo_byte = '0;

    result_t     pending_results[$];
    stim_row_t   directed_rows[$];
    int unsigned beats_sent = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned s_run_left = 0;
    bit          s_calm = 1'b0;
    int unsigned m_run_left = 0;
    bit          m_calm = 1'b0;

    frame_descramble_check_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_is_status (m_is_status),
        .m_msg_id    (m_msg_id),
        .m_frame_len (m_frame_len),
        .m_check_ok  (m_check_ok),
        .m_last      (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // gaps come in runs: some runs never idle, others draw a random idle gap before each beat
    function automatic int unsigned next_gap(inout int unsigned run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(5, 60);
            calm = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        if (calm)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic result_t status_of(logic [WORD_W-1:0] id, logic [WORD_W-1:0] flen,
                                          logic ok);
        result_t r;
        r = '0;
        r.is_status = 1'b1;
        r.msg_id    = id;
        r.frame_len = flen;
        r.check_ok  = ok;
        r.last      = 1'b1;
        return r;
    endfunction

    task automatic descramble_step(input logic [BYTE_W-1:0] din, output bit produced,
                                   output result_t res);
        logic [WORD_W-1:0] trailer_word;
        logic [BYTE_W-1:0] key;
        produced = 1'b0;
        res = '0;
        case (cur_phase)
            PH_LEN_HI: begin
                hdr_len[15:8] = din;
                cur_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                hdr_id = {8'h00, din};
                cur_phase = PH_ID_HI;
            end
            PH_ID_HI: begin
                hdr_id[15:8] = din;
                remain = hdr_len;
                use_id_key = 1'b0;
                cur_phase = (hdr_len != 0) ? PH_PAYLOAD : PH_TRL_LO;
            end
            PH_PAYLOAD: begin
                // keys alternate length low byte, id low byte
                key = use_id_key ? hdr_id[7:0] : hdr_len[7:0];
                use_id_key = !use_id_key;
                remain = remain - 1'b1;
                if (remain == 0)
                    cur_phase = PH_TRL_LO;
                produced = 1'b1;
                res.out_byte  = din ^ key;
                res.msg_id    = hdr_id;
                res.frame_len = hdr_len + LEN_BIAS;
            end
            PH_TRL_LO: begin
                trl_lo_byte = din;
                cur_phase = PH_TRL_HI;
            end
            PH_TRL_HI: begin
                trailer_word = {din, trl_lo_byte};
                produced = 1'b1;
                res = status_of(hdr_id, hdr_len + LEN_BIAS,
                                trailer_word == hdr_len + LEN_BIAS);
                cur_phase = PH_LEN_LO;
            end
            default: begin
                hdr_len = {8'h00, din};
                cur_phase = PH_LEN_HI;
            end
        endcase
    endtask

    // typed rows replace the predicted result with the one written in the table
    task automatic send_beat(input logic [BYTE_W-1:0] din, input bit typed, input result_t want);
        int unsigned gap;
        bit          produced;
        result_t     res;
        gap = next_gap(s_run_left, s_calm);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= din;
        do @(posedge aclk); while (s_ready !== 1'b1);
        beats_sent++;
        descramble_step(din, produced, res);
        if (produced)
            pending_results.push_back(typed ? want : res);
    endtask

    task automatic add_row(input logic [BYTE_W-1:0] din, input bit typed, input result_t want);
        stim_row_t row;
        row.din   = din;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_frame();
        int unsigned       sel;
        int unsigned       len;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] chk;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            len = 0;
        else if (sel < 85)
            len = $urandom_range(1, 12);
        else if (sel < 97)
            len = $urandom_range(13, 40);
        else if (beats_sent + 710 < RAND_BEATS)
            len = $urandom_range(256, 700);
        else
            len = $urandom_range(1, 12);
        id = WORD_W'($urandom);
        chk = WORD_W'(len + 6);
        sel = $urandom_range(0, 99);
        if (sel >= 85)
            chk = WORD_W'($urandom);
        else if (sel >= 70)
            chk ^= WORD_W'(1) << $urandom_range(0, 15);
        send_beat(len[7:0], 1'b0, '0);
        send_beat(len[15:8], 1'b0, '0);
        send_beat(id[7:0], 1'b0, '0);
        send_beat(id[15:8], 1'b0, '0);
        repeat (len) send_beat(BYTE_W'($urandom), 1'b0, '0);
        send_beat(chk[7:0], 1'b0, '0);
        send_beat(chk[15:8], 1'b0, '0);
    endtask

    // header whose payload count is wrong, then filler until a frame boundary
    task automatic send_broken();
        int unsigned len;
        int unsigned n;
        len = $urandom_range(0, 10);
        n = $urandom_range(0, len + 3);
        if (n == len)
            n++;
        send_beat(len[7:0], 1'b0, '0);
        send_beat(8'h00, 1'b0, '0);
        send_beat(BYTE_W'($urandom), 1'b0, '0);
        send_beat(BYTE_W'($urandom), 1'b0, '0);
        repeat (n + 2) send_beat(BYTE_W'($urandom), 1'b0, '0);
        // zero length high byte keeps any header read from noise short
        while (cur_phase != PH_LEN_LO)
            send_beat((cur_phase == PH_LEN_HI) ? 8'h00 : BYTE_W'($urandom), 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // result side
    initial begin
        int unsigned gap;
        result_t     got;
        result_t     want;
        wait (aresetn === 1'b1);
        forever begin
            gap = next_gap(m_run_left, m_calm);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.out_byte  = m_out_byte;
            got.is_status = m_is_status;
            got.msg_id    = m_msg_id;
            got.frame_len = m_frame_len;
            got.check_ok  = m_check_ok;
            got.last      = m_last;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display({"%0t: unexpected beat: expected none, got byte=%h status=%b ",
                              "id=%h len=%h ok=%b last=%b"},
                             $time, got.out_byte, got.is_status, got.msg_id, got.frame_len,
                             got.check_ok, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.out_byte !== want.out_byte || got.is_status !== want.is_status ||
                    got.msg_id !== want.msg_id || got.frame_len !== want.frame_len ||
                    got.check_ok !== want.check_ok || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected byte=%h status=%b id=%h len=%h ",
                                  "ok=%b last=%b, got byte=%h status=%b id=%h len=%h ok=%b last=%b"},
                                 $time, want.out_byte, want.is_status, want.msg_id,
                                 want.frame_len, want.check_ok, want.last,
                                 got.out_byte, got.is_status, got.msg_id, got.frame_len,
                                 got.check_ok, got.last);
                end
            end
        end
    end

    initial begin
        // empty payload right after reset, extreme id, good check
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h06, 1'b0, '0);
        add_row(8'h00, 1'b1, status_of(16'hFFFF, 16'd6, 1'b1));
        // odd payload, extreme data bytes, failing check
        add_row(8'h03, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'hAB, 1'b0, '0);
        add_row(8'h12, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h5A, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'hFF, 1'b1, status_of(16'h12AB, 16'd9, 1'b0));
        // next byte after a failed check starts a new header; key restarts
        add_row(8'h01, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h80, 1'b0, '0);
        add_row(8'h07, 1'b0, '0);
        add_row(8'h00, 1'b1, status_of(16'h00FF, 16'd7, 1'b1));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].din, directed_rows[i].typed, directed_rows[i].want);

        while (beats_sent < RAND_BEATS) begin
            if ($urandom_range(0, 99) < 12)
                send_broken();
            else
                send_frame();
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/fdc_pkg.sv
rtl/core/fdc_deframe.sv
rtl/core/frame_descramble_check_unit.sv
tb/tb_top.sv
